// ===== hw/rtl/median_by_insertion_sort_unit_assert.svh =====
// Assertion macros for the median insertion-sort unit.
// Used by median_by_insertion_sort_unit; depends on nothing else.
`ifndef MEDIAN_BY_INSERTION_SORT_UNIT_ASSERT_SVH
`define MEDIAN_BY_INSERTION_SORT_UNIT_ASSERT_SVH

`ifndef ASSERT_OFF
`define MSORT_ASSERT_IMP(lbl, clk, rst, pre, post, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);
`define MSORT_ASSERT_NEXT(lbl, clk, rst, pre, post, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);
`else
`define MSORT_ASSERT_IMP(lbl, clk, rst, pre, post, msg)
`define MSORT_ASSERT_NEXT(lbl, clk, rst, pre, post, msg)
`endif

`endif

// ===== hw/rtl/msort_pkg.sv =====
// Shared types and constants for the median insertion-sort unit.
// No dependencies.
package msort_pkg;

   localparam int MaxSamples   = 64;
   localparam int SampleW      = 16;
   localparam int MedianW      = 17;
   localparam int SampleCountW = 7;
   localparam int CountW       = $clog2(MaxSamples + 1);
   localparam int RemainW      = CountW - 1;

   typedef logic signed [SampleW-1:0] sample_type;
   typedef logic [CountW-1:0]         count_type;
   typedef logic [RemainW-1:0]        remain_type;

   typedef struct packed {
      sample_type sample;
      logic       last;
   } req_type;

   typedef struct packed {
      logic signed [MedianW-1:0] median_halves;
      logic [SampleCountW-1:0]   sample_count;
      logic                      overflow;
   } rsp_type;

   typedef struct packed {
      logic       insert;
      logic       shift;
      sample_type key;
   } cell_ctrl_type;

   typedef enum logic {
      MSORT_IDLE,
      MSORT_DRAIN
   } state_type;

endpackage

// ===== hw/rtl/msort_cell.sv =====
// One cell of the sorted insertion chain: holds one sample.
// Depends on msort_pkg.
module msort_cell (
   input  logic                     clock,
   input  msort_pkg::cell_ctrl_type ctrl,
   input  logic                     occupied,
   input  logic                     left_gt,
   input  msort_pkg::sample_type    left_val,
   input  msort_pkg::sample_type    right_val,
   output logic                     gt,
   output msort_pkg::sample_type    val
);

   msort_pkg::sample_type val_ff;
   msort_pkg::sample_type val_in;

   assign gt  = !occupied || (val_ff > ctrl.key);
   assign val = val_ff;

   always_comb begin
      priority if (ctrl.shift) begin
         val_in = right_val;
      end else if (ctrl.insert && gt) begin
         val_in = left_gt ? left_val : ctrl.key;
      end else begin
         val_in = val_ff;
      end
   end

   always_ff @(posedge clock) begin
      val_ff <= val_in;
   end

endmodule

// ===== hw/rtl/msort_chain.sv =====
// Row of msort_cell instances forming an ascending sorted store.
// Depends on msort_pkg and msort_cell.
module msort_chain (
   input  logic                     clock,
   input  msort_pkg::cell_ctrl_type ctrl,
   input  msort_pkg::count_type     count,
   output msort_pkg::sample_type    head0,
   output msort_pkg::sample_type    head1
);

   msort_pkg::sample_type vals [msort_pkg::MaxSamples];
   logic                  gts  [msort_pkg::MaxSamples];

   for (genvar i = 0; i < msort_pkg::MaxSamples; i++) begin : g_cell
      logic                  occ;
      logic                  lgt;
      msort_pkg::sample_type lval;
      msort_pkg::sample_type rval;

      assign occ = msort_pkg::CountW'(i) < count;

      if (i == 0) begin : g_first
         assign lgt  = 1'b0;
         assign lval = ctrl.key;
      end else begin : g_inner
         assign lgt  = gts[i-1];
         assign lval = vals[i-1];
      end

      if (i == msort_pkg::MaxSamples - 1) begin : g_end
         assign rval = vals[i];
      end else begin : g_mid
         assign rval = vals[i+1];
      end

      msort_cell u_cell (
         .clock     (clock),
         .ctrl      (ctrl),
         .occupied  (occ),
         .left_gt   (lgt),
         .left_val  (lval),
         .right_val (rval),
         .gt        (gts[i]),
         .val       (vals[i])
      );
   end

   assign head0 = vals[0];
   assign head1 = vals[1];

endmodule

// ===== hw/rtl/median_by_insertion_sort_unit.sv =====
// Median by insertion sort: samples enter a chain of 64 sorting cells, one per cycle while not busy.
// After the transfer of a last sample the chain shifts down one place a cycle to bring the middle
// to its head; the median and the rsp_valid strobe are then registered.
// Throughput: one sample per cycle within a set; busy holds during the shift-down.
// Reset (synchronous, active high) empties the set and clears the overflow flag and strobe.
// Results cannot be stalled; rsp_valid is high for exactly one cycle per set.
`include "median_by_insertion_sort_unit_assert.svh"
module median_by_insertion_sort_unit (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  msort_pkg::req_type req_item,
   output logic               rsp_valid,
   output msort_pkg::rsp_type rsp_item
);

   msort_pkg::state_type     state_ff;
   msort_pkg::state_type     state_in;
   msort_pkg::count_type     count_ff;
   msort_pkg::count_type     count_in;
   logic                     dropped_ff;
   logic                     dropped_in;
   msort_pkg::remain_type    remain_ff;
   msort_pkg::remain_type    remain_in;
   logic                     rsp_valid_ff;
   logic                     rsp_valid_in;
   msort_pkg::rsp_type       rsp_item_ff;
   msort_pkg::rsp_type       rsp_item_in;

   msort_pkg::cell_ctrl_type ctrl;
   msort_pkg::sample_type    head0;
   msort_pkg::sample_type    head1;
   msort_pkg::count_type     count_new;
   msort_pkg::count_type     half_new;
   logic                     accept;
   logic                     full;
   logic signed [msort_pkg::MedianW-1:0] med_a;
   logic signed [msort_pkg::MedianW-1:0] med_b;

   msort_chain u_chain (
      .clock (clock),
      .ctrl  (ctrl),
      .count (count_ff),
      .head0 (head0),
      .head1 (head1)
   );

   assign busy      = (state_ff != msort_pkg::MSORT_IDLE);
   assign accept    = start && !busy;
   assign full      = (count_ff == msort_pkg::CountW'(msort_pkg::MaxSamples));
   assign count_new = full ? count_ff : count_ff + msort_pkg::CountW'(1);
   assign half_new  = (count_new - msort_pkg::CountW'(1)) >> 1;
   assign med_a     = {head0[msort_pkg::SampleW-1], head0};
   assign med_b     = count_ff[0] ? {head0[msort_pkg::SampleW-1], head0}
                                  : {head1[msort_pkg::SampleW-1], head1};

   always_comb begin
      state_in                  = state_ff;
      count_in                  = count_ff;
      dropped_in                = dropped_ff;
      remain_in                 = remain_ff;
      rsp_valid_in              = 1'b0;
      rsp_item_in               = rsp_item_ff;
      ctrl.key                  = req_item.sample;
      ctrl.insert               = 1'b0;
      ctrl.shift                = 1'b0;
      unique case (state_ff)
         msort_pkg::MSORT_IDLE: begin
            if (accept) begin
               ctrl.insert = !full;
               count_in    = count_new;
               dropped_in  = dropped_ff || full;
               if (req_item.last) begin
                  remain_in = half_new[msort_pkg::RemainW-1:0];
                  state_in  = msort_pkg::MSORT_DRAIN;
               end
            end
         end
         msort_pkg::MSORT_DRAIN: begin
            if (remain_ff != '0) begin
               ctrl.shift = 1'b1;
               remain_in  = remain_ff - msort_pkg::RemainW'(1);
            end else begin
               rsp_valid_in               = 1'b1;
               rsp_item_in.median_halves  = med_a + med_b;
               rsp_item_in.sample_count   = msort_pkg::SampleCountW'(count_ff);
               rsp_item_in.overflow       = dropped_ff;
               count_in                   = '0;
               dropped_in                 = 1'b0;
               state_in                   = msort_pkg::MSORT_IDLE;
            end
         end
         default: begin
            state_in = msort_pkg::MSORT_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= msort_pkg::MSORT_IDLE;
         count_ff     <= '0;
         dropped_ff   <= 1'b0;
         remain_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         dropped_ff   <= dropped_in;
         remain_ff    <= remain_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_item_ff <= rsp_item_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

   `MSORT_ASSERT_IMP(a_count_bound, clock, reset, 1'b1,
      count_ff <= msort_pkg::CountW'(msort_pkg::MaxSamples), "count above capacity")
   `MSORT_ASSERT_IMP(a_rsp_nonempty, clock, reset, rsp_valid_ff,
      rsp_item_ff.sample_count != '0, "result from an empty set")
   `MSORT_ASSERT_NEXT(a_drain_done, clock, reset,
      (state_ff == msort_pkg::MSORT_DRAIN) && (remain_ff == '0), rsp_valid_ff, "missing result")
   `MSORT_ASSERT_NEXT(a_strobe_single, clock, reset, rsp_valid_ff, !rsp_valid_ff,
      "result strobe longer than one cycle")

endmodule
